// ===== hw/rtl/srb_pkg.sv =====
// Shared types and constants for the sequence reorder buffer.
package srb_pkg;

  localparam int SRB_TABLE_DEPTH = 32;
  localparam int SRB_MAX_RESULTS = 32;

  localparam logic [15:0] SUFFIX_BYTES = 16'd8;
  localparam logic [5:0]  LIMIT_RESET  = 6'd32;

  localparam logic [1:0] KIND_DELIVERED = 2'd0;
  localparam logic [1:0] KIND_MALFORMED = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [63:0] frame_sequence;
    logic [15:0] frame_length;
    logic [31:0] payload_tag;
  } frame_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] delivered_sequence;
    logic [31:0] delivered_tag;
    logic [15:0] delivered_length;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [31:0] tag;
    logic [15:0] len;
  } entry_t;

endpackage

// ===== hw/rtl/sequence_reorder_buffer_unit.sv =====
// Top level of the sequence reorder buffer: sequencer, entry store and result register.
// A short frame gives its error in the cycle after the transfer and leaves the unit free. Others
// are searched across the whole table and then decided, where an overflow ends; else a drain
// delivers the stored frames in sequence order and a flush gives the last of the run, all
// through one 64-bit comparator behind the single store read port. Results come one per cycle
// at most and cannot be held off; synchronous reset clears expected sequence, count and valids.
module sequence_reorder_buffer_unit
  import srb_pkg::*;
#(
  parameter int TABLE_DEPTH = SRB_TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  frame_t     frame,
  output logic       result_valid,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int NW   = $clog2(SRB_MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DRAIN,
    S_FLUSH
  } state_t;

  state_t           state;
  logic [5:0]       reorder_limit;
  logic [63:0]      expected;
  logic [CW-1:0]    count;
  logic [TABLE_DEPTH-1:0] valid;

  frame_t           cur;
  logic             is_new;
  logic             dup;
  logic             free_found;
  logic [IW-1:0]    free_idx;

  logic [IW-1:0]    scan_idx;
  logic [IW-1:0]    cmp_idx;
  logic             cmp_vld;
  logic [IW-1:0]    step_cnt;
  logic [NW-1:0]    n_out;

  logic             pend_vld;
  entry_t           pend;

  logic             rd_en;
  entry_t           rd_data;
  logic             wr_en;
  entry_t           wr_data;
  logic [63:0]      key;
  logic             match;
  logic             accept;
  logic             overflow;
  logic [IW-1:0]    scan_idx_next;

  assign busy      = (state != S_IDLE);
  // The limit only changes between frames, never under one in progress.
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign rd_en = (state == S_SCAN) || (state == S_DRAIN);

  // The one comparator serves the duplicate search and the drain.
  assign key   = (state == S_SCAN) ? cur.frame_sequence : expected;
  assign match = cmp_vld && valid[cmp_idx] && (rd_data.seq == key);

  assign overflow = (CMPW'(count) >= CMPW'(reorder_limit)) || !free_found;
  assign wr_en    = (state == S_DECIDE) && is_new && !dup && !overflow;
  assign wr_data  = '{seq: cur.frame_sequence, tag: cur.payload_tag,
                      len: cur.frame_length - SUFFIX_BYTES};

  assign scan_idx_next = (scan_idx == IW'(TABLE_DEPTH - 1)) ? '0 : scan_idx + 1'b1;

  srb_entry_ram #(
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(free_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(scan_idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reorder_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reorder_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      expected     <= '0;
      count        <= '0;
      valid        <= '0;
      result_valid <= 1'b0;
      cmp_vld      <= 1'b0;
      pend_vld     <= 1'b0;
      dup          <= 1'b0;
      free_found   <= 1'b0;
      is_new       <= 1'b0;
      scan_idx     <= '0;
      step_cnt     <= '0;
      n_out        <= '0;
      free_idx     <= '0;
      cmp_idx      <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (accept) begin
            if (frame.frame_length < SUFFIX_BYTES) begin
              result_valid <= 1'b1;
              result       <= '{result_kind: KIND_MALFORMED, delivered_sequence: '0,
                                delivered_tag: '0, delivered_length: '0,
                                last_of_run: 1'b1};
            end else begin
              cur        <= frame;
              is_new     <= (frame.frame_sequence >= expected);
              dup        <= 1'b0;
              free_found <= 1'b0;
              scan_idx   <= '0;
              step_cnt   <= '0;
              n_out      <= '0;
              pend_vld   <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          scan_idx <= scan_idx_next;
          cmp_idx  <= scan_idx;
          cmp_vld  <= 1'b1;
          if (cmp_vld) begin
            if (match) begin
              dup <= 1'b1;
            end
            if (!valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            step_cnt <= step_cnt + 1'b1;
            if (step_cnt == IW'(TABLE_DEPTH - 1)) begin
              cmp_vld <= 1'b0;
              state   <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          scan_idx <= '0;
          step_cnt <= '0;
          cmp_vld  <= 1'b0;
          if (is_new && !dup && overflow) begin
            result_valid <= 1'b1;
            result       <= '{result_kind: KIND_OVERFLOW, delivered_sequence: '0,
                              delivered_tag: '0, delivered_length: '0,
                              last_of_run: 1'b1};
            state        <= S_IDLE;
          end else begin
            if (wr_en) begin
              valid[free_idx] <= 1'b1;
              count           <= count + 1'b1;
            end
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          scan_idx <= scan_idx_next;
          cmp_idx  <= scan_idx;
          cmp_vld  <= 1'b1;
          if (match) begin
            // A delivered frame is held back one hit so that the run's end can be marked.
            valid[cmp_idx] <= 1'b0;
            if (count != '0) begin
              count <= count - 1'b1;
            end
            expected <= expected + 64'd1;
            step_cnt <= '0;
            n_out    <= n_out + 1'b1;
            pend_vld <= 1'b1;
            pend     <= rd_data;
            if (pend_vld) begin
              result_valid <= 1'b1;
              result       <= '{result_kind: KIND_DELIVERED,
                                delivered_sequence: pend.seq, delivered_tag: pend.tag,
                                delivered_length: pend.len, last_of_run: 1'b0};
            end
            if (n_out == NW'(SRB_MAX_RESULTS - 1)) begin
              cmp_vld <= 1'b0;
              state   <= S_FLUSH;
            end
          end else if (cmp_vld) begin
            step_cnt <= step_cnt + 1'b1;
            if (step_cnt == IW'(TABLE_DEPTH - 1)) begin
              cmp_vld <= 1'b0;
              state   <= S_FLUSH;
            end
          end
        end

        S_FLUSH: begin
          cmp_vld <= 1'b0;
          if (pend_vld) begin
            result_valid <= 1'b1;
            result       <= '{result_kind: KIND_DELIVERED,
                              delivered_sequence: pend.seq, delivered_tag: pend.tag,
                              delivered_length: pend.len, last_of_run: 1'b1};
          end
          pend_vld <= 1'b0;
          state    <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count differs from the number of valid entries");

  a_write_to_free_slot: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !valid[free_idx])
    else $error("insert would overwrite a valid entry");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy || start))
    else $error("result given without an item in progress");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_kind != KIND_DELIVERED) |-> result.last_of_run)
    else $error("error result not marked as the last of its run");

  a_drain_advances: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && match) |=> (expected == $past(expected) + 64'd1))
    else $error("expected sequence did not advance on delivery");
`endif

endmodule

// ===== hw/rtl/srb_entry_ram.sv =====
// Entry store: one write port and one registered read port.
module srb_entry_ram
  import srb_pkg::*;
#(
  parameter int DEPTH = SRB_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/sequence_reorder_buffer_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sequence reorder buffer: predicts every result and compares it on arrival.
module sequence_reorder_buffer_unit_checker
  import srb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  frame_t     frame,
  input  logic       result_valid,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [5:0] cfg_data,
  output int         mismatches,
  output int         outstanding,
  output int         frames_taken,
  output int         delivered_seen,
  output int         malformed_seen,
  output int         overflow_seen
);

  localparam int DEPTH = SRB_TABLE_DEPTH;

  logic [63:0] next_seq;
  logic        held_valid [DEPTH];
  entry_t      held_entry [DEPTH];
  int unsigned held_count;
  logic [5:0]  hold_limit;
  result_t     pending_results [$];
  int          fail_total;
  int          frame_total;
  int          delivered_total;
  int          malformed_total;
  int          overflow_total;

  function automatic int find_held(input logic [63:0] s);
    for (int i = 0; i < DEPTH; i++) begin
      if (held_valid[i] && held_entry[i].seq == s) return i;
    end
    return -1;
  endfunction

  // Appends one predicted result behind those still awaited.
  task automatic expect_result(input result_t r);
    pending_results = {pending_results, r};
  endtask

  // Works out the results of one accepted frame and updates the held set.
  task automatic reorder_frame(input frame_t f);
    int unsigned cap;
    int slot;
    int n;
    result_t r;
    result_t last;
    r = '0;
    last = '0;
    if (f.frame_length < SUFFIX_BYTES) begin
      r.result_kind = KIND_MALFORMED;
      r.last_of_run = 1'b1;
      expect_result(r);
      return;
    end
    cap = (hold_limit < DEPTH) ? hold_limit : DEPTH;
    if (f.frame_sequence >= next_seq && find_held(f.frame_sequence) < 0) begin
      slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (!held_valid[i]) slot = i;
      end
      if (held_count >= cap || slot < 0) begin
        r.result_kind = KIND_OVERFLOW;
        r.last_of_run = 1'b1;
        expect_result(r);
        return;
      end
      held_valid[slot]     = 1'b1;
      held_entry[slot].seq = f.frame_sequence;
      held_entry[slot].tag = f.payload_tag;
      held_entry[slot].len = f.frame_length - SUFFIX_BYTES;
      held_count++;
    end
    // The final delivery is held back one step so that its run mark can be set.
    n = 0;
    while (n < SRB_MAX_RESULTS) begin
      slot = find_held(next_seq);
      if (slot < 0) break;
      if (n > 0) expect_result(last);
      last = '0;
      last.result_kind        = KIND_DELIVERED;
      last.delivered_sequence = held_entry[slot].seq;
      last.delivered_tag      = held_entry[slot].tag;
      last.delivered_length   = held_entry[slot].len;
      held_valid[slot] = 1'b0;
      if (held_count > 0) held_count--;
      next_seq++;
      n++;
    end
    if (n > 0) begin
      last.last_of_run = 1'b1;
      expect_result(last);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_total++;
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      next_seq   = '0;
      held_count = 0;
      hold_limit = LIMIT_RESET;
      for (int i = 0; i < DEPTH; i++) held_valid[i] = 1'b0;
      pending_results.delete();
      fail_total      = 0;
      frame_total     = 0;
      delivered_total = 0;
      malformed_total = 0;
      overflow_total  = 0;
    end else begin
      if (cfg_valid && cfg_ready) hold_limit = cfg_data;
      if (start && !busy) begin
        frame_total++;
        reorder_frame(frame);
      end
      if (result_valid) begin
        case (result.result_kind)
          KIND_DELIVERED: delivered_total++;
          KIND_MALFORMED: malformed_total++;
          KIND_OVERFLOW:  overflow_total++;
          default: ;
        endcase
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", result.delivered_sequence, '0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (result.result_kind !== want.result_kind)
            report_mismatch("result_kind", 64'(result.result_kind), 64'(want.result_kind));
          if (result.delivered_sequence !== want.delivered_sequence)
            report_mismatch("delivered_sequence", result.delivered_sequence,
                            want.delivered_sequence);
          if (result.delivered_tag !== want.delivered_tag)
            report_mismatch("delivered_tag", 64'(result.delivered_tag),
                            64'(want.delivered_tag));
          if (result.delivered_length !== want.delivered_length)
            report_mismatch("delivered_length", 64'(result.delivered_length),
                            64'(want.delivered_length));
          if (result.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 64'(result.last_of_run), 64'(want.last_of_run));
        end
      end
    end
    mismatches     <= fail_total;
    outstanding    <= pending_results.size();
    frames_taken   <= frame_total;
    delivered_seen <= delivered_total;
    malformed_seen <= malformed_total;
    overflow_seen  <= overflow_total;
  end

endmodule

// ===== sim/sequence_reorder_buffer_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the sequence reorder buffer: frame stimulus, limit writes and the verdict.
module sequence_reorder_buffer_unit_tb;
  import srb_pkg::*;

  // Long enough for a frame that delivers nothing to finish its search and drain.
  localparam int SETTLE_CYCLES = 2 * (SRB_TABLE_DEPTH + 2) + 12;
  localparam int STALL_LIMIT   = 4000;
  // Frames sent before the final fill phase, which adds about forty more.
  localparam int RANDOM_ITEMS  = 116;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  frame_t     frame = '0;
  logic       result_valid;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int frames_taken;
  int delivered_seen;
  int malformed_seen;
  int overflow_seen;
  int stall_cycles = 0;
  int limit_writes = 0;
  int counted_items = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  logic [5:0]  cur_limit = LIMIT_RESET;
  logic [63:0] base = '0;

  sequence_reorder_buffer_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .frame(frame),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  sequence_reorder_buffer_unit_checker reorder_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .frame(frame),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .frames_taken(frames_taken),
    .delivered_seen(delivered_seen),
    .malformed_seen(malformed_seen),
    .overflow_seen(overflow_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("No transfer for %0d cycles, stopping the run.", STALL_LIMIT);
      $display("** sequence_reorder_buffer_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [15:0] good_length();
    case ($urandom_range(0, 9))
      0: return SUFFIX_BYTES;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(8, 65535));
    endcase
  endfunction

  // Offers one frame and returns at the edge of its transfer, or after the gap where a gap in
  // the sender's burst pattern follows; start is left high unless such a gap follows.
  task automatic send_frame(input logic [63:0] s, input logic [15:0] len,
                            input logic [31:0] tag);
    int gap;
    frame.frame_sequence <= s;
    frame.frame_length   <= len;
    frame.payload_tag    <= tag;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    counted_items++;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(20, 90);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 7);
      end
    end
  endtask

  // Waits until every expected result has come and the unit has gone quiet.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  // Sends the w sequences from base in a shuffled order with some noise mixed in.
  // Where the limit may have turned frames away, the limit is raised and the
  // window is swept in order so that every lost frame is stored and delivered.
  task automatic run_window(input int w);
    logic [63:0] order [32];
    logic [63:0] tmp;
    int j;
    int cap;
    for (int i = 0; i < w; i++) order[i] = base + i;
    for (int i = w - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: send_frame({$urandom, $urandom}, 16'($urandom_range(0, 7)), $urandom);
          1: send_frame(base - 1 - $urandom_range(0, 7), good_length(), $urandom);
          default: if (i > 0) send_frame(order[$urandom_range(0, i - 1)], good_length(),
                                         $urandom);
        endcase
      end
      send_frame(order[i], good_length(), $urandom);
    end
    settle();
    // One far-ahead frame stays parked for the whole run and takes a place.
    cap = (cur_limit < SRB_TABLE_DEPTH) ? int'(cur_limit) : SRB_TABLE_DEPTH;
    if (cap < w + 1) begin
      write_limit($urandom_range(0, 1) ? 6'd63 : LIMIT_RESET);
      for (int i = 0; i < w; i++) send_frame(base + i, good_length(), $urandom);
      settle();
    end
    base += w;
  endtask

  initial begin
    int w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_frame(64'd0, 16'd0, 32'd0);
    send_frame('1, 16'd7, '1);
    send_frame(64'd0, SUFFIX_BYTES, '1);
    send_frame(64'd1, 16'hFFFF, 32'd0);
    send_frame(64'd4, 16'd100, 32'h1234_5678);
    send_frame(64'd3, 16'd9, 32'h0BAD_F00D);
    send_frame(64'd4, 16'd200, 32'h5555_5555);
    send_frame(64'd2, 16'd64, 32'hAAAA_AAAA);
    send_frame(64'd0, 16'd64, 32'd1);
    send_frame('1, 16'd9, $urandom);
    send_frame('1, 16'd40, $urandom);
    settle();

    // With a limit of zero every new frame is refused.
    write_limit(6'd0);
    send_frame(64'd5, 16'd20, $urandom);
    send_frame(64'h8000_0000_0000_0000, 16'd20, $urandom);
    send_frame(64'd1, 16'd20, $urandom);
    send_frame(64'd5, 16'd3, $urandom);
    settle();

    write_limit(6'd2);
    send_frame(64'd7, 16'd30, $urandom);
    send_frame(64'd6, 16'd30, $urandom);
    send_frame(64'd5, 16'd30, $urandom);
    settle();

    write_limit(6'd63);
    send_frame(64'd6, 16'd31, $urandom);
    send_frame(64'd5, 16'd32, $urandom);
    settle();
    base = 64'd8;

    while (counted_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_limit(6'd0);
          1: write_limit(6'd63);
          2: write_limit(LIMIT_RESET);
          default: write_limit(6'($urandom_range(1, 31)));
        endcase
      end
      steady = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 31) : $urandom_range(1, 8);
      run_window(w);
    end

    // Fill the store completely; after this even the expected frame is refused,
    // so this has to be the last phase of the run.
    steady = 1'b0;
    write_limit(6'd63);
    for (int i = 1; i < SRB_TABLE_DEPTH; i++) send_frame(base + i, good_length(), $urandom);
    send_frame(base, good_length(), $urandom);
    repeat (8) send_frame({$urandom, $urandom}, good_length(), $urandom);
    settle();

    $display("Frames transferred: %0d; results: %0d delivered, %0d malformed, %0d overflow.",
             frames_taken, delivered_seen, malformed_seen, overflow_seen);
    $display("Reorder limit written %0d times, from zero up to above the table depth.",
             limit_writes);
    if (mismatches == 0) begin
      $display("** sequence_reorder_buffer_unit: PASSED **");
    end else begin
      $display("** sequence_reorder_buffer_unit: FAILED **");
    end
    $finish;
  end

endmodule
